FILE: hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared item types, request and status codes and register defaults for the
// first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int FIELD_W = 14;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FIELD_W-1:0] address;
    logic [FIELD_W-1:0] request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] result_address;
    logic               moved;
    logic [FIELD_W-1:0] copy_bytes;
  } rsp_t;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_RESIZE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_SPLIT  = 1'b1;

  localparam logic [6:0]         HDR_RESET = 7'd20;
  localparam logic [FIELD_W-1:0] THR_RESET = 14'd512;

endpackage

FILE: hw/rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/first_fit_heap_allocator.sv
// Timing: a request rejected at dispatch goes straight to its result, an append
//   to an empty table follows an empty scan, and each table entry visited by a
//   search or a shift passes through the single read and write port of the
//   block table.
// Throughput: one request at a time; the next is taken once the result sits in
//   the output register. Reset: clears count, break and sequencer, loads
//   header 20 and threshold 512; the table memory is not cleared, no sweep.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit arena allocator: an address-ordered block table held in one RAM,
// walked by a sequencer that searches, splits, merges and shifts entries.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int ARENA_BYTES = 8192,
  parameter int MAX_BLOCKS  = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  ffha_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output ffha_pkg::rsp_t               rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [ffha_pkg::FIELD_W-1:0] cfg_data
);

  localparam int FW = ffha_pkg::FIELD_W;
  localparam int AW = $clog2(ARENA_BYTES + 1);  // start, size, break
  localparam int IW = $clog2(MAX_BLOCKS);       // table address
  localparam int NW = IW + 1;                   // count, can hold MAX_BLOCKS
  localparam int CW = ((AW > 15) ? AW : 15) + 2; // headroom for sums
  localparam int EW = 2 * AW + 1;               // {free, size, start}

  // Sequencer states
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DISPATCH  = 5'd1;
  localparam logic [4:0] S_SCAN_RD   = 5'd2;
  localparam logic [4:0] S_SCAN_CHK  = 5'd3;
  localparam logic [4:0] S_TAKE      = 5'd4;
  localparam logic [4:0] S_TRIM      = 5'd5;
  localparam logic [4:0] S_INS_RD    = 5'd6;
  localparam logic [4:0] S_INS_WR    = 5'd7;
  localparam logic [4:0] S_INS_PUT   = 5'd8;
  localparam logic [4:0] S_SET_N_RD  = 5'd9;
  localparam logic [4:0] S_SET_N_CHK = 5'd10;
  localparam logic [4:0] S_SET_P_RD  = 5'd11;
  localparam logic [4:0] S_SET_P_CHK = 5'd12;
  localparam logic [4:0] S_SET_LAST  = 5'd13;
  localparam logic [4:0] S_REM_RD    = 5'd14;
  localparam logic [4:0] S_REM_WR    = 5'd15;
  localparam logic [4:0] S_REL_MARK  = 5'd16;
  localparam logic [4:0] S_RSZ_CHK   = 5'd17;
  localparam logic [4:0] S_RSZ_N     = 5'd18;
  localparam logic [4:0] S_APPEND    = 5'd19;
  localparam logic [4:0] S_RET       = 5'd20;
  localparam logic [4:0] S_DONE      = 5'd21;

  // Search kinds
  localparam logic [1:0] K_ALLOC = 2'd0;  // first free block that fits
  localparam logic [1:0] K_USED  = 2'd1;  // used block with this data offset
  localparam logic [1:0] K_START = 2'd2;  // block with this start

  // Configuration
  logic [6:0]    hdr;
  logic [FW-1:0] thr;

  // Global state
  logic [NW-1:0] cnt;
  logic [AW-1:0] brk;

  // Sequencer registers
  logic [4:0]    state;
  logic [4:0]    ret_st;
  logic [1:0]    kind;
  logic [1:0]    op;
  logic [FW-1:0] addr;
  logic [CW-1:0] s;
  logic [NW-1:0] idx;
  logic [NW-1:0] sh_j;
  logic [NW-1:0] sh_at;
  logic [AW-1:0] cur_start;
  logic [AW-1:0] cur_size;
  logic [EW-1:0] ins_e;
  logic [AW-1:0] old_start;
  logic [AW-1:0] old_size;
  logic          mv_pend;
  logic [1:0]    status;
  logic [FW-1:0] res;
  logic          moved;
  logic [FW-1:0] copy;

  // Table memory
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  ffha_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Fields of the entry read last cycle
  logic [AW-1:0] rd_start;
  logic [AW-1:0] rd_size;
  logic          rd_free;
  assign rd_start = mem_rdata[AW-1:0];
  assign rd_size  = mem_rdata[2*AW-1:AW];
  assign rd_free  = mem_rdata[2*AW];

  logic [CW-1:0] hdr_c;
  logic [NW-1:0] idx_inc;
  logic [NW-1:0] idx_dec;
  logic [NW-1:0] sh_jp1;
  logic [CW-1:0] n_sum;
  logic [CW-1:0] p_sum;
  logic [CW-1:0] app_end;
  logic [CW-1:0] rd_dofs;
  logic          room;
  logic          trim_ok;
  logic          app_ok;
  logic          join_ok;
  logic          scan_hit;

  always_comb begin
    hdr_c   = CW'(hdr);
    idx_inc = idx + 1'b1;
    idx_dec = idx - 1'b1;
    sh_jp1  = sh_j + 1'b1;
    n_sum   = CW'(cur_size) + hdr_c + CW'(rd_size);
    p_sum   = CW'(rd_size) + hdr_c + CW'(cur_size);
    app_end = CW'(brk) + hdr_c + s;
    rd_dofs = CW'(rd_start) + hdr_c;
    room    = cnt < NW'(MAX_BLOCKS);
    // Split only when the spare covers a header plus the threshold
    trim_ok = (CW'(cur_size) >= s) &&
              ((CW'(cur_size) - s) >= (hdr_c + CW'(thr))) && room;
    app_ok  = room && (app_end <= CW'(ARENA_BYTES));
    join_ok = (idx_inc < cnt) && rd_free && (n_sum >= s);
    case (kind)
      K_ALLOC: scan_hit = rd_free && (CW'(rd_size) >= s);
      K_USED:  scan_hit = !rd_free && (rd_dofs == CW'(addr));
      K_START: scan_hit = rd_start == old_start;
      default: scan_hit = 1'b0;
    endcase
  end

  // Table port: one read and at most one write a cycle; where both hit the same
  // entry the read data is not used, so no forwarding is needed.
  always_comb begin
    mem_raddr = idx[IW-1:0];
    mem_we    = 1'b0;
    mem_waddr = idx[IW-1:0];
    mem_wdata = {1'b0, cur_size, cur_start};
    case (state)
      S_INS_RD:                mem_raddr = sh_j[IW-1:0];
      S_REM_RD:                mem_raddr = sh_jp1[IW-1:0];
      S_SET_N_RD, S_RSZ_CHK:   mem_raddr = idx_inc[IW-1:0];
      S_SET_P_RD:              mem_raddr = idx_dec[IW-1:0];
      default:                 mem_raddr = idx[IW-1:0];
    endcase
    case (state)
      S_TAKE: begin
        mem_we = 1'b1;
      end
      S_TRIM: begin
        mem_we    = trim_ok;
        mem_wdata = {1'b0, s[AW-1:0], cur_start};
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sh_jp1[IW-1:0];
        mem_wdata = mem_rdata;
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = sh_at[IW-1:0];
        mem_wdata = ins_e;
      end
      S_SET_N_CHK: begin
        mem_we    = rd_free;
        mem_wdata = {1'b1, n_sum[AW-1:0], cur_start};
      end
      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sh_j[IW-1:0];
        mem_wdata = mem_rdata;
      end
      S_SET_P_CHK: begin
        mem_we    = rd_free;
        mem_waddr = idx_dec[IW-1:0];
        mem_wdata = {1'b1, p_sum[AW-1:0], rd_start};
      end
      S_REL_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, cur_size, cur_start};
      end
      S_RSZ_N: begin
        mem_we    = join_ok;
        mem_wdata = {1'b0, n_sum[AW-1:0], cur_start};
      end
      S_APPEND: begin
        mem_we    = app_ok;
        mem_waddr = cnt[IW-1:0];
        mem_wdata = {1'b0, s[AW-1:0], brk};
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr <= ffha_pkg::HDR_RESET;
      thr <= ffha_pkg::THR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ffha_pkg::CFG_HEADER) begin
        hdr <= cfg_data[6:0];
      end else begin
        thr <= cfg_data;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      brk       <= '0;
      mv_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // drop a taken result; S_DONE reloads the register on its own
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.req_type;
            addr    <= req.address;
            // round up to a multiple of 4
            s       <= (CW'(req.request_size) + CW'(3)) & ~CW'(3);
            status  <= ffha_pkg::ST_INVALID;
            res     <= '0;
            moved   <= 1'b0;
            copy    <= '0;
            mv_pend <= 1'b0;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx <= '0;
          if (op == ffha_pkg::REQ_ALLOC ||
              (op == ffha_pkg::REQ_RESIZE && addr == '0)) begin
            kind  <= K_ALLOC;
            state <= S_SCAN_RD;
          end else if ((op == ffha_pkg::REQ_RELEASE || op == ffha_pkg::REQ_RESIZE) &&
                       addr != '0) begin
            kind  <= K_USED;
            state <= S_SCAN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN_RD: begin
          if (idx == cnt) begin
            // end of table: allocation goes to the break, lookups fail
            state <= (kind == K_ALLOC) ? S_APPEND : S_DONE;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (scan_hit) begin
            cur_start <= rd_start;
            cur_size  <= rd_size;
            case (kind)
              K_ALLOC: begin
                status <= ffha_pkg::ST_OK;
                res    <= FW'(rd_dofs);
                state  <= S_TAKE;
              end
              K_USED: begin
                if (op == ffha_pkg::REQ_RELEASE) begin
                  status <= ffha_pkg::ST_OK;
                  state  <= S_REL_MARK;
                end else begin
                  state <= S_RSZ_CHK;
                end
              end
              default: state <= S_REL_MARK;
            endcase
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN_RD;
          end
        end
        S_TAKE: begin
          state <= S_TRIM;
        end
        S_TRIM: begin
          if (trim_ok) begin
            // split off the tail as a free block right after this one
            ins_e <= {1'b1, AW'(CW'(cur_size) - s - hdr_c), AW'(CW'(cur_start) + hdr_c + s)};
            cur_size <= s[AW-1:0];
            sh_at    <= idx_inc;
            sh_j     <= cnt - 1'b1;
            state    <= S_INS_RD;
          end else begin
            state <= S_RET;
          end
        end
        S_INS_RD: begin
          // shift entries up from the top down to the insertion point
          state <= (sh_jp1 == sh_at) ? S_INS_PUT : S_INS_WR;
        end
        S_INS_WR: begin
          sh_j  <= sh_j - 1'b1;
          state <= S_INS_RD;
        end
        S_INS_PUT: begin
          cnt       <= cnt + 1'b1;
          idx       <= sh_at;
          cur_start <= ins_e[AW-1:0];
          cur_size  <= ins_e[2*AW-1:AW];
          state     <= S_SET_N_RD;
        end
        S_SET_N_RD: begin
          state <= (idx_inc < cnt) ? S_SET_N_CHK : S_SET_P_RD;
        end
        S_SET_N_CHK: begin
          if (rd_free) begin
            cur_size <= n_sum[AW-1:0];
            sh_j     <= idx_inc;
            ret_st   <= S_SET_P_RD;
            state    <= S_REM_RD;
          end else begin
            state <= S_SET_P_RD;
          end
        end
        S_SET_P_RD: begin
          state <= (idx != '0) ? S_SET_P_CHK : S_SET_LAST;
        end
        S_SET_P_CHK: begin
          if (rd_free) begin
            cur_start <= rd_start;
            cur_size  <= p_sum[AW-1:0];
            sh_j      <= idx;
            idx       <= idx_dec;
            ret_st    <= S_SET_LAST;
            state     <= S_REM_RD;
          end else begin
            state <= S_SET_LAST;
          end
        end
        S_SET_LAST: begin
          // a free last block goes back to the break
          if (idx_inc == cnt) begin
            brk <= cur_start;
            cnt <= cnt - 1'b1;
          end
          state <= S_RET;
        end
        S_REM_RD: begin
          // close the gap at sh_j, moving later entries down
          if (sh_jp1 == cnt) begin
            cnt   <= cnt - 1'b1;
            state <= ret_st;
          end else begin
            state <= S_REM_WR;
          end
        end
        S_REM_WR: begin
          sh_j  <= sh_jp1;
          state <= S_REM_RD;
        end
        S_REL_MARK: begin
          state <= S_SET_N_RD;
        end
        S_RSZ_CHK: begin
          if (CW'(cur_size) >= s) begin
            status <= ffha_pkg::ST_OK;
            res    <= addr;
            state  <= S_TRIM;
          end else begin
            state <= S_RSZ_N;
          end
        end
        S_RSZ_N: begin
          if (join_ok) begin
            // grow into the free successor, then trim
            cur_size <= n_sum[AW-1:0];
            status   <= ffha_pkg::ST_OK;
            res      <= addr;
            sh_j     <= idx_inc;
            ret_st   <= S_TRIM;
            state    <= S_REM_RD;
          end else begin
            // move: allocate anew, then release the old block
            old_start <= cur_start;
            old_size  <= cur_size;
            mv_pend   <= 1'b1;
            kind      <= K_ALLOC;
            idx       <= '0;
            state     <= S_SCAN_RD;
          end
        end
        S_APPEND: begin
          if (app_ok) begin
            cnt    <= cnt + 1'b1;
            brk    <= app_end[AW-1:0];
            res    <= FW'(CW'(brk) + hdr_c);
            status <= ffha_pkg::ST_OK;
            state  <= S_RET;
          end else begin
            status  <= ffha_pkg::ST_NO_SPACE;
            mv_pend <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_RET: begin
          if (mv_pend) begin
            mv_pend <= 1'b0;
            moved   <= 1'b1;
            copy    <= FW'(old_size);
            kind    <= K_START;
            idx     <= '0;
            state   <= S_SCAN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid || rsp_ready) begin
            rsp.status         <= status;
            rsp.result_address <= res;
            rsp.moved          <= moved;
            rsp.copy_bytes     <= copy;
            rsp_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Table never overflows
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= NW'(MAX_BLOCKS))
    else $error("block count above capacity");

  // Break stays inside the arena
  a_brk_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(brk) <= CW'(ARENA_BYTES))
    else $error("break beyond arena");

  // An empty table has its break at the arena base
  a_empty_brk: assert property (@(posedge clk) disable iff (rst)
    cnt == '0 |-> brk == '0)
    else $error("empty table with nonzero break");

  // No move is left pending between requests
  a_mv_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mv_pend)
    else $error("move pending while idle");

endmodule

FILE: tb/tb_first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Drives allocate, release and resize requests into the allocator under random
// idling on both channels and checks every response against a local model of
// the block table and break pointer, across several register settings.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIELD_W  = ffha_pkg::FIELD_W;
  localparam int ARENA    = 8192;
  localparam int NBLK     = 256;
  localparam int WDOG_MAX = 20000;  // cycles with no item moving on any channel
  localparam int DRAIN    = 2100;   // extra idle clocks after the final drain
  localparam int HOLD_OFF = 400;    // long receiver stall to back up the input

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_ready;
  ffha_pkg::req_t  req = '0;
  logic            rsp_valid;
  logic            rsp_ready = 1'b0;
  ffha_pkg::rsp_t  rsp;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic            cfg_index = 1'b0;
  logic [FIELD_W-1:0] cfg_data = '0;

  first_fit_heap_allocator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Heap model: table of blocks in address order plus the break.
  // --------------------------------------------------------------------------
  int unsigned blk_start [NBLK];
  int unsigned blk_size  [NBLK];
  bit          blk_free  [NBLK];
  int unsigned blk_count = 0;
  int unsigned brk       = 0;
  int unsigned hdr_bytes = ffha_pkg::HDR_RESET;
  int unsigned split_min = ffha_pkg::THR_RESET;

  ffha_pkg::req_t pending_q [$];   // items waiting to be offered
  ffha_pkg::rsp_t grant_q   [$];   // responses owed by the allocator, oldest first

  int  errors = 0;
  bit  quiet = 1'b0;          // no idling in the closing phase
  bit  pressure_go = 1'b0;
  bit  pressure_done = 1'b0;

  function automatic void tbl_insert(int unsigned at, int unsigned st,
                                     int unsigned sz, bit fr);
    for (int k = blk_count; k > at; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_size[k]  = blk_size[k-1];
      blk_free[k]  = blk_free[k-1];
    end
    blk_start[at] = st;
    blk_size[at]  = sz;
    blk_free[at]  = fr;
    blk_count++;
  endfunction

  function automatic void tbl_remove(int unsigned at);
    for (int k = at; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_size[k]  = blk_size[k+1];
      blk_free[k]  = blk_free[k+1];
    end
    blk_count--;
  endfunction

  function automatic void merge_next(int unsigned i);
    blk_size[i] += hdr_bytes + blk_size[i+1];
    tbl_remove(i + 1);
  endfunction

  // Coalesce a freshly freed block and hand it back to the break if last.
  function automatic void coalesce(int unsigned i);
    if (i + 1 < blk_count && blk_free[i+1]) merge_next(i);
    if (i > 0 && blk_free[i-1]) begin
      merge_next(i - 1);
      i--;
    end
    if (i + 1 == blk_count) begin
      brk = blk_start[i];
      tbl_remove(i);
    end
  endfunction

  function automatic void split_tail(int unsigned i, int unsigned s);
    int unsigned sz;
    sz = blk_size[i];
    if (sz >= s && sz - s >= hdr_bytes + split_min && blk_count < NBLK) begin
      tbl_insert(i + 1, blk_start[i] + hdr_bytes + s, sz - s - hdr_bytes, 1'b1);
      blk_size[i] = s;
      coalesce(i + 1);
    end
  endfunction

  function automatic bit carve(int unsigned s, output int unsigned addr);
    addr = 0;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= s) begin
        blk_free[i] = 1'b0;
        split_tail(i, s);
        addr = blk_start[i] + hdr_bytes;
        return 1'b1;
      end
    end
    if (blk_count >= NBLK || brk + hdr_bytes + s > ARENA) return 1'b0;
    tbl_insert(blk_count, brk, s, 1'b0);
    brk += hdr_bytes + s;
    addr = blk_start[blk_count-1] + hdr_bytes;
    return 1'b1;
  endfunction

  function automatic int unsigned find_owner(int unsigned addr);
    if (addr == 0) return blk_count;
    for (int unsigned i = 0; i < blk_count; i++)
      if (!blk_free[i] && blk_start[i] + hdr_bytes == addr) return i;
    return blk_count;
  endfunction

  function automatic ffha_pkg::rsp_t heap_grant(ffha_pkg::req_t r);
    ffha_pkg::rsp_t o;
    int unsigned    s, i, got, old_start, old_size;
    o = '0;
    o.status = ffha_pkg::ST_INVALID;
    s = (int'(r.request_size) + 3) & ~32'd3;
    if (r.req_type == ffha_pkg::REQ_ALLOC ||
        (r.req_type == ffha_pkg::REQ_RESIZE && r.address == 0)) begin
      if (carve(s, got)) begin
        o.status = ffha_pkg::ST_OK;
        o.result_address = got[FIELD_W-1:0];
      end else begin
        o.status = ffha_pkg::ST_NO_SPACE;
      end
    end else if (r.req_type == ffha_pkg::REQ_RELEASE) begin
      i = find_owner(r.address);
      if (i < blk_count) begin
        blk_free[i] = 1'b1;
        coalesce(i);
        o.status = ffha_pkg::ST_OK;
      end
    end else if (r.req_type == ffha_pkg::REQ_RESIZE) begin
      i = find_owner(r.address);
      if (i < blk_count) begin
        if (blk_size[i] >= s) begin
          split_tail(i, s);
          o.status = ffha_pkg::ST_OK;
          o.result_address = r.address;
        end else if (i + 1 < blk_count && blk_free[i+1] &&
                     blk_size[i] + hdr_bytes + blk_size[i+1] >= s) begin
          merge_next(i);
          split_tail(i, s);
          o.status = ffha_pkg::ST_OK;
          o.result_address = r.address;
        end else begin
          old_start = blk_start[i];
          old_size  = blk_size[i];
          if (carve(s, got)) begin
            // The old block may have shifted in the table; find it by start.
            for (i = 0; i < blk_count && blk_start[i] != old_start; i++) ;
            if (i < blk_count) begin
              blk_free[i] = 1'b1;
              coalesce(i);
            end
            o.status = ffha_pkg::ST_OK;
            o.result_address = got[FIELD_W-1:0];
            o.moved = 1'b1;
            o.copy_bytes = old_size[FIELD_W-1:0];
          end else begin
            o.status = ffha_pkg::ST_NO_SPACE;
          end
        end
      end
    end
    return o;
  endfunction

  // Data offset of a random block in use, else any 14-bit value.
  function automatic logic [FIELD_W-1:0] live_address();
    int unsigned used [$];
    int unsigned a;
    for (int unsigned i = 0; i < blk_count; i++)
      if (!blk_free[i]) used.push_back(i);
    if (used.size() == 0) return FIELD_W'($urandom);
    a = blk_start[used[$urandom_range(0, used.size() - 1)]] + hdr_bytes;
    return a[FIELD_W-1:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued items, predict each one as it is accepted.
  // --------------------------------------------------------------------------
  int unsigned req_gap = 0;

  always @(posedge clk) begin : driver
    bit fire;
    fire = req_valid && req_ready;
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      if (fire) grant_q.push_back(heap_grant(req));
      // Hold the offered item until it goes; pick the next only after that.
      if (!req_valid || fire) begin
        if (req_gap > 0) begin
          req_gap   <= req_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req       <= pending_q.pop_front();
          req_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 16);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, one long hold-off, field-by-field checks.
  // --------------------------------------------------------------------------
  int unsigned rsp_hold = 0;

  always @(posedge clk) begin : monitor
    ffha_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected response, status", rsp.status, -1);
      end else begin
        want = grant_q.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.result_address !== want.result_address)
          report_mismatch("result_address", rsp.result_address, want.result_address);
        if (rsp.moved !== want.moved)
          report_mismatch("moved", rsp.moved, want.moved);
        if (rsp.copy_bytes !== want.copy_bytes)
          report_mismatch("copy_bytes", rsp.copy_bytes, want.copy_bytes);
      end
    end
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_hold  <= rsp_hold - 1;
      rsp_ready <= 1'b0;
    end else if (pressure_go && !pressure_done) begin
      pressure_done <= 1'b1;
      rsp_hold      <= HOLD_OFF;
      rsp_ready     <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rsp_hold  <= $urandom_range(0, 15);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int unsigned stuck = 0;

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= WDOG_MAX) begin
      $display("[first_fit_heap_allocator] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push(logic [1:0] t, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] s);
    ffha_pkg::req_t r;
    r.req_type = t;
    r.address = a;
    r.request_size = s;
    pending_q.push_back(r);
  endtask

  // Wait until every queued item has gone and every response has come back.
  task automatic drain();
    while (pending_q.size() != 0 || req_valid || grant_q.size() != 0) @(posedge clk);
  endtask

  // Only called with the allocator idle.
  task automatic write_reg(logic idx, int unsigned val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val[FIELD_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ffha_pkg::CFG_HEADER) hdr_bytes = val & 32'h7F;
    else split_min = val & 32'h3FFF;
  endtask

  function automatic logic [FIELD_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return FIELD_W'($urandom_range(0, 300));
    if (r < 95) return FIELD_W'($urandom_range(0, 2000));
    return FIELD_W'($urandom);
  endfunction

  // Mostly well-formed traffic on live blocks, with some noise.
  task automatic random_batch(int n);
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      push(ffha_pkg::REQ_ALLOC, FIELD_W'($urandom), pick_size());
      else if (r < 70) push(ffha_pkg::REQ_RELEASE, live_address(), FIELD_W'($urandom));
      else if (r < 90) push(ffha_pkg::REQ_RESIZE, live_address(), pick_size());
      else if (r < 94) push(ffha_pkg::REQ_RELEASE, FIELD_W'($urandom), FIELD_W'($urandom));
      else if (r < 97) push(ffha_pkg::REQ_RESIZE,
                            $urandom_range(0, 1) ? '0 : FIELD_W'($urandom), pick_size());
      else             push(2'd3, FIELD_W'($urandom), FIELD_W'($urandom));
    end
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k += 10) begin
      random_batch(10);
      drain();
    end
  endtask

  initial begin
    logic [FIELD_W-1:0] a;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, each request type and the corner cases.
    push(ffha_pkg::REQ_ALLOC, '0, '0);
    push(ffha_pkg::REQ_ALLOC, '0, 14'd100);
    push(ffha_pkg::REQ_ALLOC, 14'h3FFF, 14'd1000);
    drain();
    push(ffha_pkg::REQ_RESIZE, live_address(), 14'd8);     // shrink, split if the spare allows
    push(ffha_pkg::REQ_RELEASE, '0, '0);                   // null address
    push(ffha_pkg::REQ_RELEASE, 14'd3, 14'h3FFF);          // not a block
    push(2'd3, 14'h3FFF, 14'h3FFF);                        // unknown type
    push(ffha_pkg::REQ_ALLOC, '0, 14'h3FFF);               // no space
    push(ffha_pkg::REQ_ALLOC, '0, 14'd8192);
    push(ffha_pkg::REQ_RESIZE, '0, 14'd40);                // resize of null allocates
    drain();
    a = live_address();
    push(ffha_pkg::REQ_RELEASE, a, '0);
    push(ffha_pkg::REQ_RELEASE, a, '0);                    // already free
    drain();
    push(ffha_pkg::REQ_RESIZE, live_address(), 14'd4000);  // grow or move
    push(ffha_pkg::REQ_RESIZE, live_address(), 14'd8192);  // move fails
    push(ffha_pkg::REQ_ALLOC, '0, 14'd3);
    drain();
    push(ffha_pkg::REQ_RESIZE, live_address(), 14'd2000);
    push(ffha_pkg::REQ_RELEASE, live_address(), '0);
    drain();
    push(ffha_pkg::REQ_RELEASE, live_address(), '0);
    push(ffha_pkg::REQ_RELEASE, live_address(), '0);
    drain();

    random_phase(300);

    // Smallest header and no split threshold: splits at every chance.
    write_reg(ffha_pkg::CFG_HEADER, 4);
    write_reg(ffha_pkg::CFG_SPLIT, 0);
    random_phase(150);

    // Long receiver stall while the sender keeps offering items.
    random_batch(40);
    pressure_go <= 1'b1;
    drain();
    random_phase(340);

    // Largest header and a threshold that never splits.
    write_reg(ffha_pkg::CFG_HEADER, 64);
    write_reg(ffha_pkg::CFG_SPLIT, 8192);
    random_phase(300);

    write_reg(ffha_pkg::CFG_HEADER, $urandom_range(4, 64));
    write_reg(ffha_pkg::CFG_SPLIT, $urandom_range(0, 8192));
    random_phase(300);

    // Closing phase back at reset values, no idling on either side.
    write_reg(ffha_pkg::CFG_HEADER, ffha_pkg::HDR_RESET);
    write_reg(ffha_pkg::CFG_SPLIT, ffha_pkg::THR_RESET);
    quiet = 1'b1;
    random_phase(300);

    drain();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("[first_fit_heap_allocator] OK");
    end else begin
      $display("[first_fit_heap_allocator] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/first_fit_heap_allocator.sv
tb/tb_first_fit_heap_allocator.sv
